[rtl/core/iude_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iude_pkg
// Shared types and constants of the interval union delay engine.
// ---------------------------------------------------------------------------
package iude_pkg;

	localparam logic REQ_INTERVAL = 1'b0;
	localparam logic REQ_FLUSH    = 1'b1;

	localparam logic KIND_INTERVAL = 1'b0;
	localparam logic KIND_SUMMARY  = 1'b1;

	localparam logic SIDE_SERVER = 1'b0;
	localparam logic SIDE_CLIENT = 1'b1;

	localparam logic MODE_CLAMP = 1'b0;
	localparam logic MODE_HOST  = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 328;

	typedef struct packed {
		logic        flush;
		logic [1:0]  cpu;
		logic        side;
		logic [63:0] start_ns;
		logic [63:0] end_ns;
	} cmd_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  out_cpu;
		logic        out_side;
		logic [63:0] merged_start;
		logic [63:0] merged_end;
		logic [63:0] server_covered;
		logic [63:0] client_covered;
		logic [63:0] local_delay;
		logic        last;
	} res_t;

endpackage

[rtl/core/iude_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iude_front
// Input beat stage: drops filtered and out-of-range intervals, registers
// the remaining commands for the queue.
// ---------------------------------------------------------------------------
module iude_front #(
	parameter int NUM_CPUS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [iude_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	output logic                           push_valid,
	input  logic                           push_ready,
	output iude_pkg::cmd_t                 push_cmd
);

	logic           stage_valid_s1;
	iude_pkg::cmd_t cmd_s1;
	logic           accept;
	logic           keep;
	logic           filtered;
	logic [1:0]     cpu;

	assign cpu      = s_tdata[1:0];
	assign filtered = s_tdata[131];
	assign keep     = (s_tuser == iude_pkg::REQ_FLUSH) ||
	                  (!filtered && (32'(cpu) < NUM_CPUS));

	assign s_tready = !stage_valid_s1 || push_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s1 <= 1'b0;
		end else if (accept) begin
			stage_valid_s1 <= keep;
		end else if (push_ready) begin
			stage_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			cmd_s1.flush    <= s_tuser;
			cmd_s1.cpu      <= cpu;
			cmd_s1.side     <= s_tdata[2];
			cmd_s1.start_ns <= s_tdata[66:3];
			cmd_s1.end_ns   <= s_tdata[130:67];
		end
	end

	assign push_valid = stage_valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

[rtl/core/iude_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iude_queue
// Short command queue between the front stage and the back sequencer.
// ---------------------------------------------------------------------------
module iude_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  iude_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output iude_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(iude_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(iude_pkg::QUEUE_DEPTH + 1);

	iude_pkg::cmd_t entry_q [iude_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(iude_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(iude_pkg::QUEUE_DEPTH - 1)) ? '0 :
				            wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(iude_pkg::QUEUE_DEPTH - 1)) ? '0 :
				            rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(iude_pkg::QUEUE_DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("queue overfilled");

	property p_pop_moves;
		@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1);
	endproperty
	a_pop_moves: assert property (p_pop_moves) else $error("queue count slip");

	property p_push_blocked;
		@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(iude_pkg::QUEUE_DEPTH)) |-> !push_ready;
	endproperty
	a_push_blocked: assert property (p_push_blocked) else $error("push into full queue");

endmodule

[rtl/core/iude_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iude_back
// Merge sequencer: per-entry open interval store, covered-time totals,
// end-of-batch walk and summary, output register.
// ---------------------------------------------------------------------------
module iude_back #(
	parameter int NUM_CPUS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  iude_pkg::cmd_t pop_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output iude_pkg::res_t out_res
);

	localparam int ENTRIES = 2 * NUM_CPUS;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int WALK_W  = IDX_W + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ICMP = 3'd1;
	localparam logic [2:0] ST_IAPL = 3'd2;
	localparam logic [2:0] ST_FCHK = 3'd3;
	localparam logic [2:0] ST_FEM  = 3'd4;
	localparam logic [2:0] ST_SDIF = 3'd5;
	localparam logic [2:0] ST_SEM  = 3'd6;

	logic [63:0] mem_start [ENTRIES];
	logic [63:0] mem_end   [ENTRIES];

	logic [2:0]         state_q;
	logic               mode_q;
	logic [ENTRIES-1:0] valid_q;
	logic [63:0]        server_q;
	logic [63:0]        client_q;
	logic [IDX_W-1:0]   idx_q;
	logic               side_q;
	logic [63:0]        start_q;
	logic [63:0]        end_q;
	logic [WALK_W-1:0]  walk_q;
	logic [63:0]        rd_start_q;
	logic [63:0]        rd_end_q;
	logic               upd_wr_q;
	logic               upd_emit_q;
	logic [63:0]        span_q;
	logic [63:0]        diff_q;
	logic               zero_q;
	logic               out_valid_q;
	iude_pkg::res_t     res_q;

	logic             out_free;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] pop_idx;
	logic [6:0]       pop_idx_full;
	logic [6:0]       idx_full;
	logic [6:0]       walk_full;
	logic [IDX_W-1:0] walk_idx;
	logic             ent_valid;
	logic             lt_s;
	logic             lt_e;
	logic [63:0]      span_new;
	logic [63:0]      span_ext;
	logic             nx_wr;
	logic             nx_emit;
	logic [63:0]      nx_span;
	logic [63:0]      delay;
	logic             res_load;
	iude_pkg::res_t   res_d;

	assign out_free     = !out_valid_q || out_ready;
	assign pop_ready    = (state_q == ST_IDLE);
	assign pop_idx_full = {4'b0, pop_cmd.cpu, pop_cmd.side};
	assign pop_idx      = pop_idx_full[IDX_W-1:0];
	assign idx_full     = 7'(idx_q);
	assign walk_idx     = walk_q[IDX_W-1:0];
	assign walk_full    = 7'(walk_idx);

	assign rd_en   = (state_q == ST_IDLE && pop_valid && !pop_cmd.flush) ||
	                 (state_q == ST_FCHK && walk_q != WALK_W'(ENTRIES) && valid_q[walk_idx]);
	assign rd_addr = (state_q == ST_IDLE) ? pop_idx : walk_idx;
	assign wr_en   = (state_q == ST_IAPL) && upd_wr_q && (!upd_emit_q || out_free);

	// an extension keeps the open start
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_start[idx_q] <= (ent_valid && !upd_emit_q) ? rd_start_q : start_q;
			mem_end[idx_q]   <= end_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_start_q <= mem_start[rd_addr];
			rd_end_q   <= mem_end[rd_addr];
		end
	end

	assign ent_valid = valid_q[idx_q];
	assign lt_s      = rd_end_q < start_q;
	assign lt_e      = rd_end_q < end_q;
	assign span_new  = end_q - start_q;
	assign span_ext  = end_q - rd_end_q;

	always_comb begin
		nx_wr   = 1'b0;
		nx_emit = 1'b0;
		nx_span = '0;
		if (!ent_valid) begin
			nx_wr   = 1'b1;
			nx_span = span_new;
		end else if (lt_s) begin
			nx_wr   = 1'b1;
			nx_emit = 1'b1;
			nx_span = span_new;
		end else if (lt_e) begin
			nx_wr   = 1'b1;
			nx_span = span_ext;
		end
	end

	always_comb begin
		if (mode_q == iude_pkg::MODE_CLAMP) begin
			delay = diff_q[63] ? '0 : diff_q;
			if (zero_q) begin
				delay = '1;
			end
		end else begin
			delay = diff_q[63] ? '1 : diff_q;
		end
	end

	always_comb begin
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			ST_IAPL: begin
				res_load           = upd_emit_q && out_free;
				res_d.result_kind  = iude_pkg::KIND_INTERVAL;
				res_d.out_cpu      = idx_full[2:1];
				res_d.out_side     = idx_full[0];
				res_d.merged_start = rd_start_q;
				res_d.merged_end   = rd_end_q;
			end
			ST_FEM: begin
				res_load           = out_free;
				res_d.result_kind  = iude_pkg::KIND_INTERVAL;
				res_d.out_cpu      = walk_full[2:1];
				res_d.out_side     = walk_full[0];
				res_d.merged_start = rd_start_q;
				res_d.merged_end   = rd_end_q;
			end
			ST_SEM: begin
				res_load             = out_free;
				res_d.result_kind    = iude_pkg::KIND_SUMMARY;
				res_d.server_covered = server_q;
				res_d.client_covered = client_q;
				res_d.local_delay    = delay;
				res_d.last           = 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= iude_pkg::MODE_CLAMP;
			valid_q     <= '0;
			server_q    <= '0;
			client_q    <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						walk_q  <= '0;
						state_q <= pop_cmd.flush ? ST_FCHK : ST_ICMP;
					end
				end
				ST_ICMP: begin
					state_q <= ST_IAPL;
				end
				ST_IAPL: begin
					if (!upd_emit_q || out_free) begin
						if (upd_wr_q) begin
							valid_q[idx_q] <= 1'b1;
						end
						if (side_q == iude_pkg::SIDE_SERVER) begin
							server_q <= server_q + span_q;
						end else begin
							client_q <= client_q + span_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FCHK: begin
					if (walk_q == WALK_W'(ENTRIES)) begin
						state_q <= ST_SDIF;
					end else if (valid_q[walk_idx]) begin
						state_q <= ST_FEM;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				ST_FEM: begin
					if (out_free) begin
						walk_q  <= walk_q + 1'b1;
						state_q <= ST_FCHK;
					end
				end
				ST_SDIF: begin
					state_q <= ST_SEM;
				end
				ST_SEM: begin
					if (out_free) begin
						valid_q  <= '0;
						server_q <= '0;
						client_q <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			idx_q   <= pop_idx;
			side_q  <= pop_cmd.side;
			start_q <= pop_cmd.start_ns;
			end_q   <= pop_cmd.end_ns;
		end
		if (state_q == ST_ICMP) begin
			upd_wr_q   <= nx_wr;
			upd_emit_q <= nx_emit;
			span_q     <= nx_span;
		end
		if (state_q == ST_SDIF) begin
			diff_q <= server_q - client_q;
			zero_q <= (server_q == '0) && (client_q == '0);
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	property p_clear_after_summary;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEM && out_free) |=> (valid_q == '0 && server_q == '0 && client_q == '0);
	endproperty
	a_clear_after_summary: assert property (p_clear_after_summary)
		else $error("state not cleared after summary");

	property p_walk_bound;
		@(posedge clk) disable iff (!arst_n)
		walk_q <= WALK_W'(ENTRIES);
	endproperty
	a_walk_bound: assert property (p_walk_bound) else $error("walk past last entry");

	property p_emit_open_only;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IAPL && upd_emit_q) |-> valid_q[idx_q];
	endproperty
	a_emit_open_only: assert property (p_emit_open_only)
		else $error("closing an entry that is not open");

	property p_flush_emit_open;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FEM) |-> valid_q[walk_idx];
	endproperty
	a_flush_emit_open: assert property (p_flush_emit_open)
		else $error("flush emits an empty entry");

endmodule

[rtl/core/interval_union_delay_engine_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interval_union_delay_engine_unit
// Per-CPU, per-side interval merging with covered-time totals and delay.
// ---------------------------------------------------------------------------
// An interval beat passes through the back sequencer as a store read, a
// compare and an update, using the single read port of the open-interval
// store; the update waits while a closing result cannot be registered.
// Filtered beats and beats for a CPU at or above NUM_CPUS are dropped in the
// front stage. At end of batch the sequencer visits each of the 2*NUM_CPUS
// entries once, reads and emits the open ones, then forms the summary. A
// two-deep command queue lets input beats be taken while the back is busy,
// and the output register lets work go on while a result beat waits.
module interval_union_delay_engine_unit #(
	parameter int NUM_CPUS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,  // negative_delay_mode
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cpu[1:0], side[2], start_ns[66:3], end_ns[130:67], filtered_out[131]
	input  logic [iude_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,    // req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_cpu[1:0], out_side[2], merged_start[66:3], merged_end[130:67],
	// server_covered[194:131], client_covered[258:195], local_delay[322:259]
	output logic [iude_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser,    // result_kind
	output logic                           m_tlast
);

	logic           push_valid;
	logic           push_ready;
	iude_pkg::cmd_t push_cmd;
	logic           pop_valid;
	logic           pop_ready;
	iude_pkg::cmd_t pop_cmd;
	iude_pkg::res_t res;

	iude_front #(
		.NUM_CPUS (NUM_CPUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	iude_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	iude_back #(
		.NUM_CPUS (NUM_CPUS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {5'b0, res.local_delay, res.client_covered, res.server_covered,
	                  res.merged_end, res.merged_start, res.out_side, res.out_cpu};
	assign m_tuser = res.result_kind;
	assign m_tlast = res.last;

endmodule
